// File: rtl/core/particle_velocity_integrator_defines.svh
// ----------------------------------------------------------------------------
// Particle velocity integrator assertion macros
// Shared assertion forms for the integrator; they compile away when
// NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_VELOCITY_INTEGRATOR_DEFINES_SVH
`define PARTICLE_VELOCITY_INTEGRATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PVI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("integrator check failed");

`define PVI_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("integrator latency check failed");

`else

`define PVI_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define PVI_ASSERT_DELAY(label, clk, rst, ante, n, cons)

`endif

`endif

// File: rtl/core/pvi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle velocity integrator package
// Types, register codes, reset values and helpers shared by the integrator.
// ----------------------------------------------------------------------------
package pvi_pkg;

   typedef enum logic [1:0] {
      REG_DAMPING,
      REG_SPEED_LIMIT,
      REG_STEP_LIMIT,
      REG_DENSITY_FLOOR
   } reg_index_type;

   localparam logic [15:0] DAMPING_RESET = 16'd65208;
   localparam logic [30:0] SPEED_LIMIT_RESET = 31'd786432;
   localparam logic [15:0] STEP_LIMIT_RESET = 16'd1049;
   localparam logic [30:0] DENSITY_FLOOR_RESET = 31'd66;

   localparam int unsigned DIV1_NW = 48;
   localparam int unsigned DIV1_QW = 47;
   localparam int unsigned DIV1_DW = 31;
   localparam int unsigned SQRT_STEPS = 32;
   localparam int unsigned DIV2_NW = 62;
   localparam int unsigned DIV2_QW = 32;
   localparam int unsigned DIV2_DW = 32;

   typedef struct packed {
      logic [15:0] step_limit;
      logic [30:0] density_floor;
   } front_cfg_type;

   typedef struct packed {
      logic [15:0] damping;
      logic [30:0] speed_limit;
   } back_cfg_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [2:0][46:0] mag;
      logic [2:0]       neg;
      logic [30:0]      dens;
      logic [15:0]      dt;
      logic             active;
   } item_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [2:0]       neg;
      logic [15:0]      dt;
      logic             active;
   } div1_side_type;

   typedef struct packed {
      logic [63:0]      s2;
      logic [61:0]      lim2;
      logic [2:0][61:0] ml;
      logic [2:0][31:0] v2;
      logic [2:0]       sgn;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [15:0]      dt;
      logic             active;
   } sqrt_side_type;

   typedef struct packed {
      logic [2:0][31:0] v2;
      logic [2:0]       sgn;
      logic             clamp;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [15:0]      dt;
      logic             active;
   } div2_side_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic             clamped;
   } rsp_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/core/pvi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined three-lane divider
// Restoring division, one quotient bit per stage, shared divisor, with a
// sideband carried alongside each transfer.
// ----------------------------------------------------------------------------
module pvi_div #(
   parameter int unsigned NW = 48,
   parameter int unsigned QW = 47,
   parameter int unsigned DW = 31,
   parameter int unsigned SW = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [2:0][NW-1:0]     num,
   input  logic [DW-1:0]          den,
   input  logic [SW-1:0]          side_in,
   output logic                   out_valid,
   output logic [2:0][QW-1:0]     quo,
   output logic [2:0]             rem_nz,
   output logic [SW-1:0]          side_out
);

   logic [2:0][DW-1:0] rem_ff [0:QW];
   logic [2:0][DW-1:0] rem_in [0:QW];
   logic [2:0][QW-1:0] low_ff [0:QW];
   logic [2:0][QW-1:0] low_in [0:QW];
   logic [2:0][QW-1:0] quo_ff [0:QW];
   logic [2:0][QW-1:0] quo_in [0:QW];
   logic [DW-1:0]      den_ff [0:QW];
   logic [DW-1:0]      den_in [0:QW];
   logic [SW-1:0]      side_ff [0:QW];
   logic [SW-1:0]      side_in_s [0:QW];
   logic [QW:0]        vld_ff;
   logic [QW:0]        vld_in;

   always_comb begin
      logic [DW:0] trial;
      logic        ge;
      for (int l = 0; l < 3; l++) begin
         rem_in[0][l] = DW'(num[l][NW-1:QW]);
         low_in[0][l] = num[l][QW-1:0];
         quo_in[0][l] = '0;
      end
      den_in[0] = den;
      side_in_s[0] = side_in;
      vld_in[0] = in_valid;
      for (int k = 0; k < QW; k++) begin
         for (int l = 0; l < 3; l++) begin
            trial = {rem_ff[k][l], low_ff[k][l][QW-1]};
            ge = (trial >= {1'b0, den_ff[k]});
            rem_in[k+1][l] = ge ? DW'(trial - {1'b0, den_ff[k]}) : trial[DW-1:0];
            low_in[k+1][l] = {low_ff[k][l][QW-2:0], 1'b0};
            quo_in[k+1][l] = {quo_ff[k][l][QW-2:0], ge};
         end
         den_in[k+1] = den_ff[k];
         side_in_s[k+1] = side_ff[k];
         vld_in[k+1] = vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QW; k++) begin
         rem_ff[k] <= rem_in[k];
         low_ff[k] <= low_in[k];
         quo_ff[k] <= quo_in[k];
         den_ff[k] <= den_in[k];
         side_ff[k] <= side_in_s[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         rem_nz[l] = |rem_ff[QW][l];
      end
   end

   assign out_valid = vld_ff[QW];
   assign quo = quo_ff[QW];
   assign side_out = side_ff[QW];

endmodule

// File: rtl/core/pvi_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root of a 64-bit value, one result bit per
// stage, with a sideband carried alongside each transfer.
// ----------------------------------------------------------------------------
module pvi_sqrt #(
   parameter int unsigned SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [63:0]   x,
   input  logic [SW-1:0] side_in,
   output logic          out_valid,
   output logic [31:0]   root,
   output logic [SW-1:0] side_out
);

   localparam int unsigned STEPS = pvi_pkg::SQRT_STEPS;

   logic [35:0]   rem_ff [0:STEPS];
   logic [35:0]   rem_in [0:STEPS];
   logic [31:0]   root_ff [0:STEPS];
   logic [31:0]   root_in [0:STEPS];
   logic [63:0]   xs_ff [0:STEPS];
   logic [63:0]   xs_in [0:STEPS];
   logic [SW-1:0] side_ff [0:STEPS];
   logic [SW-1:0] side_in_s [0:STEPS];
   logic [STEPS:0] vld_ff;
   logic [STEPS:0] vld_in;

   always_comb begin
      logic [35:0] rt;
      logic [35:0] trial;
      logic        ge;
      rem_in[0] = '0;
      root_in[0] = '0;
      xs_in[0] = x;
      side_in_s[0] = side_in;
      vld_in[0] = in_valid;
      for (int k = 0; k < STEPS; k++) begin
         rt = {rem_ff[k][33:0], xs_ff[k][63:62]};
         trial = {2'b00, root_ff[k], 2'b01};
         ge = (rt >= trial);
         rem_in[k+1] = ge ? (rt - trial) : rt;
         root_in[k+1] = {root_ff[k][30:0], ge};
         xs_in[k+1] = {xs_ff[k][61:0], 2'b00};
         side_in_s[k+1] = side_ff[k];
         vld_in[k+1] = vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= STEPS; k++) begin
         rem_ff[k] <= rem_in[k];
         root_ff[k] <= root_in[k];
         xs_ff[k] <= xs_in[k];
         side_ff[k] <= side_in_s[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign root = root_ff[STEPS];
   assign side_out = side_ff[STEPS];

endmodule

// File: rtl/core/pvi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrator front end
// Captures a particle, clamps the step, floors the density and forms the
// force-times-step products as magnitude and sign.
// ----------------------------------------------------------------------------
module pvi_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [2:0][31:0]        pos,
   input  logic [2:0][31:0]        vel,
   input  logic [2:0][31:0]        frc,
   input  logic [31:0]             density,
   input  logic [15:0]             time_step,
   input  logic                    active,
   input  pvi_pkg::front_cfg_type  cfg,
   output logic                    push,
   output pvi_pkg::item_type       push_item
);

   logic [15:0] dt_in;
   logic [30:0] floor_eff;
   logic [30:0] dens_in;

   logic             f1_vld_ff;
   logic [2:0][31:0] f1_pos_ff;
   logic [2:0][31:0] f1_vel_ff;
   logic [2:0][31:0] f1_frc_ff;
   logic [30:0]      f1_dens_ff;
   logic [15:0]      f1_dt_ff;
   logic             f1_active_ff;

   logic [2:0][48:0] prod_in;
   logic             f2_vld_ff;
   logic [2:0][31:0] f2_pos_ff;
   logic [2:0][31:0] f2_vel_ff;
   logic [2:0][48:0] f2_prod_ff;
   logic [30:0]      f2_dens_ff;
   logic [15:0]      f2_dt_ff;
   logic             f2_active_ff;

   always_comb begin
      dt_in = (time_step > cfg.step_limit) ? cfg.step_limit : time_step;
      floor_eff = (cfg.density_floor == '0) ? 31'd1 : cfg.density_floor;
      dens_in = ($signed(density) < $signed({1'b0, floor_eff})) ? floor_eff : density[30:0];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_pos_ff <= pos;
         f1_vel_ff <= vel;
         f1_frc_ff <= frc;
         f1_dens_ff <= dens_in;
         f1_dt_ff <= dt_in;
         f1_active_ff <= active;
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         prod_in[l] = $signed(f1_frc_ff[l]) * $signed({1'b0, f1_dt_ff});
      end
   end

   always_ff @(posedge clock) begin
      f2_pos_ff <= f1_pos_ff;
      f2_vel_ff <= f1_vel_ff;
      f2_prod_ff <= prod_in;
      f2_dens_ff <= f1_dens_ff;
      f2_dt_ff <= f1_dt_ff;
      f2_active_ff <= f1_active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else begin
         f1_vld_ff <= accept;
         f2_vld_ff <= f1_vld_ff;
      end
   end

   always_comb begin
      logic [48:0] mag_full;
      push_item.pos = f2_pos_ff;
      push_item.vel = f2_vel_ff;
      push_item.dens = f2_dens_ff;
      push_item.dt = f2_dt_ff;
      push_item.active = f2_active_ff;
      for (int l = 0; l < 3; l++) begin
         push_item.neg[l] = f2_prod_ff[l][48];
         mag_full = f2_prod_ff[l][48] ? (49'd0 - f2_prod_ff[l]) : f2_prod_ff[l];
         push_item.mag[l] = mag_full[46:0];
      end
   end

   assign push = f2_vld_ff;

endmodule

// File: rtl/core/pvi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrator item queue
// Short register queue between the front end and the back end. It reports
// busy early enough to absorb the items still inside the front end.
// ----------------------------------------------------------------------------
module pvi_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pvi_pkg::item_type  push_item,
   input  logic               pop,
   output logic               pop_valid,
   output pvi_pkg::item_type  pop_item,
   output logic               busy
);

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pvi_pkg::item_type mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_pop;

   always_comb begin
      do_pop = pop && (count_ff != '0);
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_item = mem_ff[rd_ptr_ff];
   assign busy = (count_ff >= CNT_W'(DEPTH - 2));

endmodule

// File: rtl/core/pvi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrator back end
// Velocity update, damping, speed limiting and position advance as one
// pipeline built around two dividers and a square root unit.
// ----------------------------------------------------------------------------
module pvi_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  pvi_pkg::item_type      item,
   input  pvi_pkg::back_cfg_type  cfg,
   output logic                   rsp_valid,
   output pvi_pkg::rsp_type       rsp
);

   localparam int unsigned SW1 = $bits(pvi_pkg::div1_side_type);
   localparam int unsigned SW2 = $bits(pvi_pkg::sqrt_side_type);
   localparam int unsigned SW3 = $bits(pvi_pkg::div2_side_type);

   // Force over density.
   logic [2:0][pvi_pkg::DIV1_NW-1:0] d1_num;
   pvi_pkg::div1_side_type d1_side_in;
   logic [SW1-1:0] d1_side_vec;
   logic d1_vld;
   logic [2:0][pvi_pkg::DIV1_QW-1:0] d1_quo;
   logic [2:0] d1_nz;
   pvi_pkg::div1_side_type d1_side;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         d1_num[l] = {1'b0, item.mag[l]};
      end
      d1_side_in.pos = item.pos;
      d1_side_in.vel = item.vel;
      d1_side_in.neg = item.neg;
      d1_side_in.dt = item.dt;
      d1_side_in.active = item.active;
   end

   pvi_div #(
      .NW(pvi_pkg::DIV1_NW),
      .QW(pvi_pkg::DIV1_QW),
      .DW(pvi_pkg::DIV1_DW),
      .SW(SW1)
   ) u_div_force (
      .clock(clock),
      .reset(reset),
      .in_valid(in_valid),
      .num(d1_num),
      .den(item.dens),
      .side_in(d1_side_in),
      .out_valid(d1_vld),
      .quo(d1_quo),
      .rem_nz(d1_nz),
      .side_out(d1_side_vec)
   );

   assign d1_side = d1_side_vec;

   // Velocity change with floor rounding.
   logic [2:0][48:0] dv_in;
   logic [2:0][48:0] b1_dv_ff;
   pvi_pkg::div1_side_type b1_side_ff;
   logic b1_vld_ff;

   always_comb begin
      logic [48:0] qext;
      for (int l = 0; l < 3; l++) begin
         qext = {2'b00, d1_quo[l]};
         dv_in[l] = d1_side.neg[l] ? (~qext + 49'(!d1_nz[l])) : qext;
      end
   end

   always_ff @(posedge clock) begin
      b1_dv_ff <= dv_in;
      b1_side_ff <= d1_side;
   end

   // Saturated velocity sum.
   logic [2:0][31:0] v1_in;
   logic [2:0][31:0] b2_v1_ff;
   pvi_pkg::div1_side_type b2_side_ff;
   logic b2_vld_ff;

   always_comb begin
      logic signed [48:0] sum;
      for (int l = 0; l < 3; l++) begin
         sum = $signed({{17{b1_side_ff.vel[l][31]}}, b1_side_ff.vel[l]}) +
               $signed(b1_dv_ff[l]);
         v1_in[l] = pvi_pkg::sat32({{15{sum[48]}}, sum});
      end
   end

   always_ff @(posedge clock) begin
      b2_v1_ff <= v1_in;
      b2_side_ff <= b1_side_ff;
   end

   // Damping product.
   logic [2:0][48:0] pd_in;
   logic [2:0][48:0] b3_pd_ff;
   pvi_pkg::div1_side_type b3_side_ff;
   logic b3_vld_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         pd_in[l] = $signed(b2_v1_ff[l]) * $signed({1'b0, cfg.damping});
      end
   end

   always_ff @(posedge clock) begin
      b3_pd_ff <= pd_in;
      b3_side_ff <= b2_side_ff;
   end

   // Damped velocity, magnitude and sign.
   logic [2:0][31:0] v2_in;
   logic [2:0][30:0] m_in;
   logic [2:0][31:0] b4_v2_ff;
   logic [2:0][30:0] b4_m_ff;
   pvi_pkg::div1_side_type b4_side_ff;
   logic b4_vld_ff;

   always_comb begin
      logic [31:0] neg_v;
      for (int l = 0; l < 3; l++) begin
         v2_in[l] = b3_pd_ff[l][47:16];
         neg_v = 32'd0 - b3_pd_ff[l][47:16];
         m_in[l] = b3_pd_ff[l][47] ? neg_v[30:0] : b3_pd_ff[l][46:16];
      end
   end

   always_ff @(posedge clock) begin
      b4_v2_ff <= v2_in;
      b4_m_ff <= m_in;
      b4_side_ff <= b3_side_ff;
   end

   // Squares and limit products.
   logic [2:0][61:0] sq_in;
   logic [2:0][61:0] ml_in;
   logic [61:0]      lim2_in;
   logic [2:0][61:0] b5_sq_ff;
   logic [2:0][61:0] b5_ml_ff;
   logic [61:0]      b5_lim2_ff;
   logic [2:0][31:0] b5_v2_ff;
   pvi_pkg::div1_side_type b5_side_ff;
   logic b5_vld_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         sq_in[l] = 62'(b4_m_ff[l]) * 62'(b4_m_ff[l]);
         ml_in[l] = 62'(b4_m_ff[l]) * 62'(cfg.speed_limit);
      end
      lim2_in = 62'(cfg.speed_limit) * 62'(cfg.speed_limit);
   end

   always_ff @(posedge clock) begin
      b5_sq_ff <= sq_in;
      b5_ml_ff <= ml_in;
      b5_lim2_ff <= lim2_in;
      b5_v2_ff <= b4_v2_ff;
      b5_side_ff <= b4_side_ff;
   end

   // Squared speed.
   pvi_pkg::sqrt_side_type b6_side_in;
   pvi_pkg::sqrt_side_type b6_side_ff;
   logic b6_vld_ff;

   always_comb begin
      b6_side_in.s2 = 64'(b5_sq_ff[0]) + 64'(b5_sq_ff[1]) + 64'(b5_sq_ff[2]);
      b6_side_in.lim2 = b5_lim2_ff;
      b6_side_in.ml = b5_ml_ff;
      b6_side_in.v2 = b5_v2_ff;
      for (int l = 0; l < 3; l++) begin
         b6_side_in.sgn[l] = b5_v2_ff[l][31];
      end
      b6_side_in.pos = b5_side_ff.pos;
      b6_side_in.vel = b5_side_ff.vel;
      b6_side_in.dt = b5_side_ff.dt;
      b6_side_in.active = b5_side_ff.active;
   end

   always_ff @(posedge clock) begin
      b6_side_ff <= b6_side_in;
   end

   logic sq_vld;
   logic [31:0] sq_root;
   logic [SW2-1:0] sq_side_vec;
   pvi_pkg::sqrt_side_type sq_side;

   pvi_sqrt #(
      .SW(SW2)
   ) u_sqrt (
      .clock(clock),
      .reset(reset),
      .in_valid(b6_vld_ff),
      .x(b6_side_ff.s2),
      .side_in(b6_side_ff),
      .out_valid(sq_vld),
      .root(sq_root),
      .side_out(sq_side_vec)
   );

   assign sq_side = sq_side_vec;

   // Limit decision.
   pvi_pkg::div2_side_type b7_side_in;
   pvi_pkg::div2_side_type b7_side_ff;
   logic [2:0][61:0] b7_ml_ff;
   logic [31:0]      b7_root_ff;
   logic b7_vld_ff;

   always_comb begin
      b7_side_in.v2 = sq_side.v2;
      b7_side_in.sgn = sq_side.sgn;
      b7_side_in.clamp = (sq_side.s2 > {2'b00, sq_side.lim2});
      b7_side_in.pos = sq_side.pos;
      b7_side_in.vel = sq_side.vel;
      b7_side_in.dt = sq_side.dt;
      b7_side_in.active = sq_side.active;
   end

   always_ff @(posedge clock) begin
      b7_side_ff <= b7_side_in;
      b7_ml_ff <= sq_side.ml;
      b7_root_ff <= sq_root;
   end

   logic d2_vld;
   logic [2:0][pvi_pkg::DIV2_QW-1:0] d2_quo;
   logic [2:0] d2_nz;
   logic [SW3-1:0] d2_side_vec;
   pvi_pkg::div2_side_type d2_side;

   pvi_div #(
      .NW(pvi_pkg::DIV2_NW),
      .QW(pvi_pkg::DIV2_QW),
      .DW(pvi_pkg::DIV2_DW),
      .SW(SW3)
   ) u_div_speed (
      .clock(clock),
      .reset(reset),
      .in_valid(b7_vld_ff),
      .num(b7_ml_ff),
      .den(b7_root_ff),
      .side_in(b7_side_ff),
      .out_valid(d2_vld),
      .quo(d2_quo),
      .rem_nz(d2_nz),
      .side_out(d2_side_vec)
   );

   assign d2_side = d2_side_vec;

   // Limited velocity.
   logic [2:0][31:0] v3_in;
   logic [2:0][31:0] b8_v3_ff;
   pvi_pkg::div2_side_type b8_side_ff;
   logic b8_vld_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (d2_side.clamp) begin
            v3_in[l] = d2_side.sgn[l] ? (32'd0 - d2_quo[l]) : d2_quo[l];
         end else begin
            v3_in[l] = d2_side.v2[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      b8_v3_ff <= v3_in;
      b8_side_ff <= d2_side;
   end

   // Displacement product.
   logic [2:0][48:0] pp_in;
   logic [2:0][48:0] b9_pp_ff;
   logic [2:0][31:0] b9_v3_ff;
   pvi_pkg::div2_side_type b9_side_ff;
   logic b9_vld_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         pp_in[l] = $signed(b8_v3_ff[l]) * $signed({1'b0, b8_side_ff.dt});
      end
   end

   always_ff @(posedge clock) begin
      b9_pp_ff <= pp_in;
      b9_v3_ff <= b8_v3_ff;
      b9_side_ff <= b8_side_ff;
   end

   // Position update and result register.
   pvi_pkg::rsp_type rsp_in;
   pvi_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;

   always_comb begin
      logic signed [33:0] psum;
      for (int l = 0; l < 3; l++) begin
         psum = $signed({{2{b9_side_ff.pos[l][31]}}, b9_side_ff.pos[l]}) +
                $signed({b9_pp_ff[l][48], b9_pp_ff[l][48:16]});
         if (b9_side_ff.active) begin
            rsp_in.pos[l] = pvi_pkg::sat32({{30{psum[33]}}, psum});
            rsp_in.vel[l] = b9_v3_ff[l];
         end else begin
            rsp_in.pos[l] = b9_side_ff.pos[l];
            rsp_in.vel[l] = b9_side_ff.vel[l];
         end
      end
      rsp_in.clamped = b9_side_ff.active && b9_side_ff.clamp;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff <= 1'b0;
         b2_vld_ff <= 1'b0;
         b3_vld_ff <= 1'b0;
         b4_vld_ff <= 1'b0;
         b5_vld_ff <= 1'b0;
         b6_vld_ff <= 1'b0;
         b7_vld_ff <= 1'b0;
         b8_vld_ff <= 1'b0;
         b9_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_vld_ff <= d1_vld;
         b2_vld_ff <= b1_vld_ff;
         b3_vld_ff <= b2_vld_ff;
         b4_vld_ff <= b3_vld_ff;
         b5_vld_ff <= b4_vld_ff;
         b6_vld_ff <= b5_vld_ff;
         b7_vld_ff <= sq_vld;
         b8_vld_ff <= d2_vld;
         b9_vld_ff <= b8_vld_ff;
         rsp_valid_ff <= b9_vld_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

// File: rtl/core/particle_velocity_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle velocity integrator
// Semi-implicit Euler update of one particle in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// An item is accepted at a rising edge with start high and busy low. The
// front end clamps the step, floors the density and forms force times
// step; a short queue feeds the back end, which divides by the density,
// damps, limits the speed and advances the position.
// Each result is shown for one cycle with rsp_valid high. The pipeline depth
// is dominated by the 47-stage force divider, the 32-stage square root and
// the 32-stage speed divider in series.
// One item can be accepted every cycle; busy rises once the queue holds two
// items, which cannot happen since the back end never stalls. The receiver cannot
// stall, so every result is taken in the cycle it appears.
// Configuration goes through the APB port at byte addresses 0, 4, 8 and 12;
// the user must write it only while the block is idle; nothing enforces it.
// Synchronous reset empties the pipeline and queue and loads the register
// defaults; no result is produced for items in flight at reset.
// ----------------------------------------------------------------------------
`include "particle_velocity_integrator_defines.svh"

module particle_velocity_integrator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_vel_x,
   input  logic [31:0] req_vel_y,
   input  logic [31:0] req_vel_z,
   input  logic [31:0] req_force_x,
   input  logic [31:0] req_force_y,
   input  logic [31:0] req_force_z,
   input  logic [31:0] req_density,
   input  logic [15:0] req_time_step,
   input  logic        req_active,
   output logic        rsp_valid,
   output logic [31:0] rsp_new_pos_x,
   output logic [31:0] rsp_new_pos_y,
   output logic [31:0] rsp_new_pos_z,
   output logic [31:0] rsp_new_vel_x,
   output logic [31:0] rsp_new_vel_y,
   output logic [31:0] rsp_new_vel_z,
   output logic        rsp_speed_clamped,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int unsigned LATENCY = 3 + pvi_pkg::DIV1_QW + 7 + pvi_pkg::SQRT_STEPS + 2 +
                                     pvi_pkg::DIV2_QW + 4;

   logic [15:0] damping_ff;
   logic [30:0] speed_limit_ff;
   logic [15:0] step_limit_ff;
   logic [30:0] density_floor_ff;
   logic        csr_write;
   pvi_pkg::reg_index_type csr_index;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = pvi_pkg::reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff <= pvi_pkg::DAMPING_RESET;
         speed_limit_ff <= pvi_pkg::SPEED_LIMIT_RESET;
         step_limit_ff <= pvi_pkg::STEP_LIMIT_RESET;
         density_floor_ff <= pvi_pkg::DENSITY_FLOOR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            pvi_pkg::REG_DAMPING: begin
               damping_ff <= pwdata[15:0];
            end
            pvi_pkg::REG_SPEED_LIMIT: begin
               speed_limit_ff <= pwdata[30:0];
            end
            pvi_pkg::REG_STEP_LIMIT: begin
               step_limit_ff <= pwdata[15:0];
            end
            pvi_pkg::REG_DENSITY_FLOOR: begin
               density_floor_ff <= pwdata[30:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         pvi_pkg::REG_DAMPING: prdata = {16'd0, damping_ff};
         pvi_pkg::REG_SPEED_LIMIT: prdata = {1'b0, speed_limit_ff};
         pvi_pkg::REG_STEP_LIMIT: prdata = {16'd0, step_limit_ff};
         pvi_pkg::REG_DENSITY_FLOOR: prdata = {1'b0, density_floor_ff};
         default: prdata = '0;
      endcase
   end

   pvi_pkg::front_cfg_type front_cfg;
   pvi_pkg::back_cfg_type  back_cfg;
   logic                   accept;
   logic                   push;
   pvi_pkg::item_type      push_item;
   logic                   pop_valid;
   pvi_pkg::item_type      pop_item;
   pvi_pkg::rsp_type       rsp;

   assign front_cfg.step_limit = step_limit_ff;
   assign front_cfg.density_floor = density_floor_ff;
   assign back_cfg.damping = damping_ff;
   assign back_cfg.speed_limit = speed_limit_ff;
   assign accept = start && !busy;

   pvi_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .pos({req_pos_z, req_pos_y, req_pos_x}),
      .vel({req_vel_z, req_vel_y, req_vel_x}),
      .frc({req_force_z, req_force_y, req_force_x}),
      .density(req_density),
      .time_step(req_time_step),
      .active(req_active),
      .cfg(front_cfg),
      .push(push),
      .push_item(push_item)
   );

   pvi_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_item(push_item),
      .pop(pop_valid),
      .pop_valid(pop_valid),
      .pop_item(pop_item),
      .busy(busy)
   );

   pvi_back u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(pop_valid),
      .item(pop_item),
      .cfg(back_cfg),
      .rsp_valid(rsp_valid),
      .rsp(rsp)
   );

   assign rsp_new_pos_x = rsp.pos[0];
   assign rsp_new_pos_y = rsp.pos[1];
   assign rsp_new_pos_z = rsp.pos[2];
   assign rsp_new_vel_x = rsp.vel[0];
   assign rsp_new_vel_y = rsp.vel[1];
   assign rsp_new_vel_z = rsp.vel[2];
   assign rsp_speed_clamped = rsp.clamped;

   logic signed [31:0] lim_pos;
   logic signed [31:0] lim_neg;
   logic               vel_in_limit;

   always_comb begin
      lim_pos = $signed({1'b0, speed_limit_ff});
      lim_neg = -lim_pos;
      vel_in_limit = ($signed(rsp_new_vel_x) <= lim_pos) && ($signed(rsp_new_vel_x) >= lim_neg) &&
                     ($signed(rsp_new_vel_y) <= lim_pos) && ($signed(rsp_new_vel_y) >= lim_neg) &&
                     ($signed(rsp_new_vel_z) <= lim_pos) && ($signed(rsp_new_vel_z) >= lim_neg);
   end

   `PVI_ASSERT_DELAY(a_result_latency, clock, reset, accept, LATENCY, rsp_valid)
   `PVI_ASSERT_IMPLY(a_clamped_in_limit, clock, reset, rsp_valid && rsp_speed_clamped, vel_in_limit)

endmodule
